// File: sv/rsm_pkg.sv
// Shared constants, types and codes for the rotor stack stepping and mapping block.
package rsm_pkg;

  localparam int NUM_ROTORS = 4;
  localparam int LETTERS    = 26;
  localparam int LW         = 5;
  localparam int KIND_W     = 3;
  localparam int SEL_W      = 3;
  localparam int NOTCH_W    = 26;
  localparam int ROT_W      = (NUM_ROTORS > 1) ? $clog2(NUM_ROTORS) : 1;
  localparam int WT_DEPTH   = NUM_ROTORS * LETTERS;
  localparam int WT_AW      = $clog2(WT_DEPTH);

  typedef logic [LW-1:0]      letter_t;
  typedef logic [WT_AW-1:0]   wt_addr_t;
  typedef logic [ROT_W-1:0]   rotor_t;
  typedef logic [NOTCH_W-1:0] notch_t;

  typedef enum logic [KIND_W-1:0] {
    K_LOAD_WIRE  = 3'd0,
    K_LOAD_NOTCH = 3'd1,
    K_LOAD_POS   = 3'd2,
    K_FWD        = 3'd3,
    K_BWD        = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FSTEP,
    ST_FADDR,
    ST_FMAP,
    ST_BADDR,
    ST_BSCAN,
    ST_BRES,
    ST_OUT
  } state_t;

  // request to the shared modulo-26 unit: a + b, or a + 26 - b when sub is set
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    sub;
  } mu_req_t;

  typedef struct packed {
    logic     we;
    wt_addr_t waddr;
    letter_t  wdata;
    wt_addr_t raddr;
  } wt_port_t;

  function automatic wt_addr_t wt_base(rotor_t r);
    return wt_addr_t'(r) * wt_addr_t'(LETTERS);
  endfunction

endpackage

// File: sv/rsm_if.sv
// Valid/ready channel interfaces for input words and result words.
interface rsm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rsm_pkg::KIND_W-1:0]  kind;
  logic [rsm_pkg::SEL_W-1:0]   rotor_sel;
  rsm_pkg::letter_t            entry_index;
  rsm_pkg::letter_t            value;
  rsm_pkg::notch_t             notch_bits;
  rsm_pkg::letter_t            letter;

  modport source (
    output valid, kind, rotor_sel, entry_index, value, notch_bits, letter,
    input  ready
  );
  modport sink (
    input  valid, kind, rotor_sel, entry_index, value, notch_bits, letter,
    output ready
  );
endinterface

interface rsm_out_if;
  logic             valid;
  logic             ready;
  rsm_pkg::letter_t out_letter;

  modport source (output valid, out_letter, input ready);
  modport sink (input valid, out_letter, output ready);
endinterface

// File: sv/rsm_mod_unit.sv
// Shared modulo-26 add/subtract unit used by the sequencer.
module rsm_mod_unit (
  input  rsm_pkg::mu_req_t req,
  output rsm_pkg::letter_t res
);

  logic [6:0] sum;
  logic [6:0] red;

  always_comb begin
    if (req.sub) begin
      sum = 7'(req.a) + 7'(rsm_pkg::LETTERS) - 7'(req.b);
    end else begin
      sum = 7'(req.a) + 7'(req.b);
    end
    if (sum >= 7'(2 * rsm_pkg::LETTERS)) begin
      red = sum - 7'(2 * rsm_pkg::LETTERS);
    end else if (sum >= 7'(rsm_pkg::LETTERS)) begin
      red = sum - 7'(rsm_pkg::LETTERS);
    end else begin
      red = sum;
    end
  end

  assign res = red[rsm_pkg::LW-1:0];

endmodule

// File: sv/rsm_wiring_ram.sv
// Wiring table memory: one write port, one registered read port.
module rsm_wiring_ram (
  input  logic              clk,
  input  rsm_pkg::wt_port_t port,
  output rsm_pkg::letter_t  rdata
);

  rsm_pkg::letter_t mem [rsm_pkg::WT_DEPTH];
  rsm_pkg::letter_t rd_r;

  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.waddr] <= port.wdata;
    end
    rd_r <= mem[port.raddr];
  end

  assign rdata = rd_r;

endmodule

// File: sv/rotor_stack_step_and_map_core.sv
// Rotor stack stepping and substitution core: sequencer, rotor state and result register.
//
// Load words (wiring entry, notch mask, position) are applied as they are accepted. A
// forward word steps the rotors and maps the letter rotor by rotor, each rotor in a step,
// a wiring read and an unmap, through one shared modulo-26 unit and the wiring RAM read
// port. A backward word searches each rotor's 26 wiring entries one RAM read per cycle,
// leftmost rotor first, stopping at the first match. The input is not ready while a
// word is in flight; a finished result waits in the output register while the next word
// is taken. The wiring table has no reset; reading an entry never written gives an
// undefined letter.
module rotor_stack_step_and_map_core (
  input  logic      clk,
  input  logic      rst_n,
  rsm_in_if.sink    in_ch,
  rsm_out_if.source out_ch
);

  rsm_pkg::state_t  state_r, state_nxt;
  rsm_pkg::rotor_t  r_r, r_nxt;
  rsm_pkg::letter_t x_r, x_nxt;
  logic             carry_r, carry_nxt;
  rsm_pkg::letter_t pos_r   [rsm_pkg::NUM_ROTORS];
  rsm_pkg::letter_t pos_nxt [rsm_pkg::NUM_ROTORS];
  rsm_pkg::notch_t  notch_r   [rsm_pkg::NUM_ROTORS];
  rsm_pkg::notch_t  notch_nxt [rsm_pkg::NUM_ROTORS];
  rsm_pkg::letter_t i_r, i_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  rsm_pkg::letter_t cmp_i_r, cmp_i_nxt;
  rsm_pkg::letter_t hit_i_r, hit_i_nxt;
  rsm_pkg::letter_t target_r, target_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsm_pkg::letter_t out_letter_r, out_letter_nxt;

  rsm_pkg::mu_req_t  mu_req;
  rsm_pkg::letter_t  mu_res;
  rsm_pkg::wt_port_t wt_port;
  rsm_pkg::letter_t  wt_rdata;

  logic             in_acc;
  logic             step;
  logic             last_fwd;
  logic             last_bwd;
  rsm_pkg::letter_t newp;
  rsm_pkg::letter_t cur_pos;
  rsm_pkg::rotor_t  sel;

  rsm_mod_unit u_mod (
    .req (mu_req),
    .res (mu_res)
  );

  rsm_wiring_ram u_ram (
    .clk   (clk),
    .port  (wt_port),
    .rdata (wt_rdata)
  );

  assign in_ch.ready       = (state_r == rsm_pkg::ST_IDLE);
  assign in_acc            = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_letter = out_letter_r;

  assign sel      = in_ch.rotor_sel[rsm_pkg::ROT_W-1:0];
  assign cur_pos  = pos_r[r_r];
  assign last_fwd = (r_r == rsm_pkg::ROT_W'(rsm_pkg::NUM_ROTORS - 1));
  assign last_bwd = (r_r == '0);
  assign step     = (r_r == '0) || carry_r;

  always_comb begin
    state_nxt      = state_r;
    r_nxt          = r_r;
    x_nxt          = x_r;
    carry_nxt      = carry_r;
    pos_nxt        = pos_r;
    notch_nxt      = notch_r;
    i_nxt          = i_r;
    cmp_valid_nxt  = cmp_valid_r;
    cmp_i_nxt      = cmp_i_r;
    hit_i_nxt      = hit_i_r;
    target_nxt     = target_r;
    out_valid_nxt  = out_valid_r;
    out_letter_nxt = out_letter_r;
    mu_req         = '0;
    newp           = cur_pos;
    wt_port.we     = 1'b0;
    wt_port.waddr  = rsm_pkg::wt_base(sel) + rsm_pkg::wt_addr_t'(in_ch.entry_index);
    wt_port.wdata  = in_ch.value;
    wt_port.raddr  = rsm_pkg::wt_base(r_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      rsm_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (rsm_pkg::kind_t'(in_ch.kind))
            rsm_pkg::K_LOAD_WIRE: begin
              if (int'(in_ch.rotor_sel) < rsm_pkg::NUM_ROTORS &&
                  int'(in_ch.entry_index) < rsm_pkg::LETTERS) begin
                wt_port.we = 1'b1;
              end
            end
            rsm_pkg::K_LOAD_NOTCH: begin
              if (int'(in_ch.rotor_sel) < rsm_pkg::NUM_ROTORS) begin
                notch_nxt[sel] = in_ch.notch_bits;
              end
            end
            rsm_pkg::K_LOAD_POS: begin
              mu_req = '{a: in_ch.value, b: '0, sub: 1'b0};
              if (int'(in_ch.rotor_sel) < rsm_pkg::NUM_ROTORS) begin
                pos_nxt[sel] = mu_res;
              end
            end
            rsm_pkg::K_FWD: begin
              x_nxt     = in_ch.letter;
              r_nxt     = '0;
              carry_nxt = 1'b0;
              state_nxt = rsm_pkg::ST_FSTEP;
            end
            rsm_pkg::K_BWD: begin
              x_nxt     = in_ch.letter;
              r_nxt     = rsm_pkg::ROT_W'(rsm_pkg::NUM_ROTORS - 1);
              state_nxt = rsm_pkg::ST_BADDR;
            end
            default: ;
          endcase
        end
      end
      rsm_pkg::ST_FSTEP: begin
        // carry: left neighbor steps when this rotor stepped onto a notch
        mu_req = '{a: cur_pos, b: rsm_pkg::letter_t'(1), sub: 1'b0};
        if (step) begin
          newp = mu_res;
        end
        pos_nxt[r_r] = newp;
        carry_nxt    = step && notch_r[r_r][newp];
        state_nxt    = rsm_pkg::ST_FADDR;
      end
      rsm_pkg::ST_FADDR: begin
        mu_req        = '{a: x_r, b: cur_pos, sub: 1'b0};
        wt_port.raddr = rsm_pkg::wt_base(r_r) + rsm_pkg::wt_addr_t'(mu_res);
        state_nxt     = rsm_pkg::ST_FMAP;
      end
      rsm_pkg::ST_FMAP: begin
        mu_req = '{a: wt_rdata, b: cur_pos, sub: 1'b1};
        x_nxt  = mu_res;
        if (last_fwd) begin
          state_nxt = rsm_pkg::ST_OUT;
        end else begin
          r_nxt     = r_r + rsm_pkg::rotor_t'(1);
          state_nxt = rsm_pkg::ST_FSTEP;
        end
      end
      rsm_pkg::ST_BADDR: begin
        mu_req        = '{a: x_r, b: cur_pos, sub: 1'b0};
        target_nxt    = mu_res;
        i_nxt         = '0;
        cmp_valid_nxt = 1'b0;
        state_nxt     = rsm_pkg::ST_BSCAN;
      end
      rsm_pkg::ST_BSCAN: begin
        if (i_r < rsm_pkg::LW'(rsm_pkg::LETTERS)) begin
          wt_port.raddr = rsm_pkg::wt_base(r_r) + rsm_pkg::wt_addr_t'(i_r);
          i_nxt         = i_r + rsm_pkg::letter_t'(1);
          cmp_valid_nxt = 1'b1;
          cmp_i_nxt     = i_r;
        end else begin
          cmp_valid_nxt = 1'b0;
        end
        if (cmp_valid_r) begin
          if (wt_rdata == target_r) begin
            hit_i_nxt = cmp_i_r;
            state_nxt = rsm_pkg::ST_BRES;
          end else if (cmp_i_r == rsm_pkg::LW'(rsm_pkg::LETTERS - 1)) begin
            // no inverse entry: letter becomes zero
            x_nxt = '0;
            if (last_bwd) begin
              state_nxt = rsm_pkg::ST_OUT;
            end else begin
              r_nxt     = r_r - rsm_pkg::rotor_t'(1);
              state_nxt = rsm_pkg::ST_BADDR;
            end
          end
        end
      end
      rsm_pkg::ST_BRES: begin
        mu_req = '{a: hit_i_r, b: cur_pos, sub: 1'b1};
        x_nxt  = mu_res;
        if (last_bwd) begin
          state_nxt = rsm_pkg::ST_OUT;
        end else begin
          r_nxt     = r_r - rsm_pkg::rotor_t'(1);
          state_nxt = rsm_pkg::ST_BADDR;
        end
      end
      rsm_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = x_r;
          state_nxt      = rsm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsm_pkg::ST_IDLE;
      r_r         <= '0;
      carry_r     <= 1'b0;
      i_r         <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < rsm_pkg::NUM_ROTORS; k++) begin
        pos_r[k]   <= '0;
        notch_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      r_r         <= r_nxt;
      carry_r     <= carry_nxt;
      i_r         <= i_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      notch_r     <= notch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    cmp_i_r      <= cmp_i_nxt;
    hit_i_r      <= hit_i_nxt;
    target_r     <= target_nxt;
    out_letter_r <= out_letter_nxt;
  end

  a_out_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_letter_r < rsm_pkg::LW'(rsm_pkg::LETTERS))
    else $error("result letter out of range");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_pos < rsm_pkg::LW'(rsm_pkg::LETTERS))
    else $error("rotor position out of range");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsm_pkg::ST_BSCAN && cmp_valid_r) |-> cmp_i_r < rsm_pkg::LW'(rsm_pkg::LETTERS))
    else $error("wiring scan ran past the rotor");

  a_fwd_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.kind == rsm_pkg::K_FWD) |=> state_r == rsm_pkg::ST_FSTEP && r_r == '0)
    else $error("forward word did not start at rotor 0");

  a_out_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsm_pkg::ST_OUT && (!out_valid_r || out_ch.ready)) |=>
      out_valid_r && out_letter_r == $past(x_r))
    else $error("result not moved to output register");

endmodule

// File: verif/tb_rotor_stack_step_and_map_core.sv
// Self-checking testbench for the rotor stack stepping and mapping core.
module tb_rotor_stack_step_and_map_core;

  localparam int KIND_TOP     = (1 << rsm_pkg::KIND_W) - 1;
  localparam int SEL_TOP      = (1 << rsm_pkg::SEL_W) - 1;
  localparam int FIELD_TOP    = (1 << rsm_pkg::LW) - 1;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 30 * rsm_pkg::NUM_ROTORS + 40;
  localparam int CALM_WORDS   = 150;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    logic [rsm_pkg::KIND_W-1:0] kind;
    logic [rsm_pkg::SEL_W-1:0]  sel;
    rsm_pkg::letter_t           idx;
    rsm_pkg::letter_t           val;
    rsm_pkg::notch_t            notch;
    rsm_pkg::letter_t           letter;
  } word_t;

  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  rsm_in_if  in_ch ();
  rsm_out_if out_ch ();

  rotor_stack_step_and_map_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // rotor state as predicted
  rsm_pkg::letter_t wire_map   [rsm_pkg::NUM_ROTORS][rsm_pkg::LETTERS];
  rsm_pkg::notch_t  notch_mask [rsm_pkg::NUM_ROTORS];
  int               rotor_pos  [rsm_pkg::NUM_ROTORS];
  bit               need_step  [rsm_pkg::NUM_ROTORS];
  bit               stepped    [rsm_pkg::NUM_ROTORS];
  rsm_pkg::letter_t expected_letters [$];

  int perm_loaded [rsm_pkg::NUM_ROTORS][rsm_pkg::LETTERS];

  int n_errors, n_checked, n_counted;
  int n_loads, n_fwd, n_bwd, n_ignored, n_no_inverse;
  bit calm;
  int hold_req;

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic rsm_pkg::letter_t encipher(int x);
    for (int r = 0; r < rsm_pkg::NUM_ROTORS; r++) begin
      if (r == 0 || (need_step[r] && stepped[r-1])) begin
        rotor_pos[r] = (rotor_pos[r] + 1) % rsm_pkg::LETTERS;
        need_step[r] = 1'b0;
        stepped[r]   = 1'b1;
        if (r > 0) stepped[r-1] = 1'b0;
      end else begin
        stepped[r] = 1'b0;
      end
      if (r + 1 < rsm_pkg::NUM_ROTORS) need_step[r+1] = notch_mask[r][rotor_pos[r]];
      x = (int'(wire_map[r][(x + rotor_pos[r]) % rsm_pkg::LETTERS]) + rsm_pkg::LETTERS
           - rotor_pos[r]) % rsm_pkg::LETTERS;
    end
    return rsm_pkg::letter_t'(x);
  endfunction

  function automatic rsm_pkg::letter_t decipher(int x);
    int target;
    int hit;
    for (int r = rsm_pkg::NUM_ROTORS - 1; r >= 0; r--) begin
      target = (x + rotor_pos[r]) % rsm_pkg::LETTERS;
      hit = -1;
      for (int i = 0; i < rsm_pkg::LETTERS && hit < 0; i++)
        if (int'(wire_map[r][i]) == target) hit = i;
      if (hit < 0) begin
        x = 0;
        n_no_inverse++;
      end else begin
        x = (hit + rsm_pkg::LETTERS - rotor_pos[r]) % rsm_pkg::LETTERS;
      end
    end
    return rsm_pkg::letter_t'(x % rsm_pkg::LETTERS);
  endfunction

  function automatic void apply_word(word_t w);
    case (w.kind)
      rsm_pkg::K_LOAD_WIRE: begin
        n_loads++;
        if (w.sel < rsm_pkg::NUM_ROTORS && w.idx < rsm_pkg::LETTERS)
          wire_map[w.sel][w.idx] = w.val;
      end
      rsm_pkg::K_LOAD_NOTCH: begin
        n_loads++;
        if (w.sel < rsm_pkg::NUM_ROTORS) notch_mask[w.sel] = w.notch;
      end
      rsm_pkg::K_LOAD_POS: begin
        n_loads++;
        if (w.sel < rsm_pkg::NUM_ROTORS) rotor_pos[w.sel] = int'(w.val) % rsm_pkg::LETTERS;
      end
      rsm_pkg::K_FWD: begin
        n_fwd++;
        expected_letters = {expected_letters, encipher(int'(w.letter))};
      end
      rsm_pkg::K_BWD: begin
        n_bwd++;
        expected_letters = {expected_letters, decipher(int'(w.letter))};
      end
      default: n_ignored++;
    endcase
  endfunction

  always @(posedge clk) begin : in_monitor
    word_t seen;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.kind   = in_ch.kind;
      seen.sel    = in_ch.rotor_sel;
      seen.idx    = in_ch.entry_index;
      seen.val    = in_ch.value;
      seen.notch  = in_ch.notch_bits;
      seen.letter = in_ch.letter;
      apply_word(seen);
    end
  end

  always @(posedge clk) begin : out_checker
    rsm_pkg::letter_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_letters.size() == 0) begin
        report_mismatch($sformatf("unexpected result word, letter %0d", out_ch.out_letter));
      end else begin
        want = expected_letters.pop_front();
        n_checked++;
        if (out_ch.out_letter !== want)
          report_mismatch($sformatf("result %0d: out_letter %0d, expected %0d",
                                    n_checked, out_ch.out_letter, want));
      end
    end
  end

  // result sink: random stalls, plus one long hold on request
  initial begin : result_sink
    int burst;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        burst = hold_req;
        hold_req = 0;
        out_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic word_t random_word();
    word_t w;
    w.kind   = rsm_pkg::KIND_W'($urandom_range(0, KIND_TOP));
    w.sel    = rsm_pkg::SEL_W'($urandom_range(0, SEL_TOP));
    w.idx    = rsm_pkg::letter_t'($urandom_range(0, FIELD_TOP));
    w.val    = rsm_pkg::letter_t'($urandom_range(0, FIELD_TOP));
    w.notch  = rsm_pkg::notch_t'($urandom);
    w.letter = rsm_pkg::letter_t'($urandom_range(0, FIELD_TOP));
    return w;
  endfunction

  function automatic rsm_pkg::letter_t rand_letter();
    if ($urandom_range(0, 7) == 0)
      return rsm_pkg::letter_t'($urandom_range(rsm_pkg::LETTERS, FIELD_TOP));
    return rsm_pkg::letter_t'($urandom_range(0, rsm_pkg::LETTERS - 1));
  endfunction

  task automatic send_word(word_t w);
    int gap;
    gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= w.kind;
    in_ch.rotor_sel   <= w.sel;
    in_ch.entry_index <= w.idx;
    in_ch.value       <= w.val;
    in_ch.notch_bits  <= w.notch;
    in_ch.letter      <= w.letter;
    do @(posedge clk); while (!in_ch.ready);
    if (w.kind <= rsm_pkg::K_BWD) n_counted++;
  endtask

  // drop valid and wait for all outstanding results
  task automatic finish_burst();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_letters.size() != 0);
  endtask

  task automatic send_letter(rsm_pkg::kind_t k, int x);
    word_t w;
    w = random_word();
    w.kind = k;
    w.letter = rsm_pkg::letter_t'(x);
    send_word(w);
  endtask

  task automatic send_load(rsm_pkg::kind_t k, int sel, int idx, int val,
                           int unsigned notch);
    word_t w;
    w = random_word();
    w.kind  = k;
    w.sel   = rsm_pkg::SEL_W'(sel);
    w.idx   = rsm_pkg::letter_t'(idx);
    w.val   = rsm_pkg::letter_t'(val);
    w.notch = rsm_pkg::notch_t'(notch);
    send_word(w);
  endtask

  // full rotor wiring as a fresh random permutation
  task automatic reload_rotor(int r);
    int perm [rsm_pkg::LETTERS];
    int j, t;
    for (int i = 0; i < rsm_pkg::LETTERS; i++) perm[i] = i;
    for (int i = rsm_pkg::LETTERS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < rsm_pkg::LETTERS; i++) begin
      perm_loaded[r][i] = perm[i];
      send_load(rsm_pkg::K_LOAD_WIRE, r, i, perm[i], $urandom);
    end
  endtask

  task automatic test_wiring_setup();
    for (int r = 0; r < rsm_pkg::NUM_ROTORS; r++) reload_rotor(r);
    send_load(rsm_pkg::K_LOAD_WIRE, SEL_TOP, 0, 0, $urandom);
    send_load(rsm_pkg::K_LOAD_WIRE, 0, FIELD_TOP, 0, $urandom);
    send_load(rsm_pkg::K_LOAD_WIRE, 1, rsm_pkg::LETTERS, FIELD_TOP, $urandom);
    finish_burst();
  endtask

  task automatic test_forward_extremes();
    send_letter(rsm_pkg::K_FWD, 0);
    send_letter(rsm_pkg::K_FWD, rsm_pkg::LETTERS - 1);
    send_letter(rsm_pkg::K_FWD, FIELD_TOP);
    send_letter(rsm_pkg::K_FWD, rsm_pkg::LETTERS);
    finish_burst();
  endtask

  task automatic test_stepping_carry();
    for (int r = 0; r < rsm_pkg::NUM_ROTORS; r++)
      send_load(rsm_pkg::K_LOAD_NOTCH, r, 0, 0, '1);
    send_load(rsm_pkg::K_LOAD_NOTCH, SEL_TOP, 0, 0, '0);
    send_load(rsm_pkg::K_LOAD_POS, 0, 0, rsm_pkg::LETTERS - 1, $urandom);
    send_load(rsm_pkg::K_LOAD_POS, 1, 0, FIELD_TOP, $urandom);
    send_load(rsm_pkg::K_LOAD_POS, SEL_TOP, 0, 3, $urandom);
    repeat (6) send_letter(rsm_pkg::K_FWD, rand_letter());
    send_load(rsm_pkg::K_LOAD_NOTCH, 1, 0, 0, '0);
    repeat (3) send_letter(rsm_pkg::K_FWD, rand_letter());
    finish_burst();
  endtask

  task automatic test_backward_lookup();
    send_letter(rsm_pkg::K_BWD, 0);
    send_letter(rsm_pkg::K_BWD, rsm_pkg::LETTERS - 1);
    send_letter(rsm_pkg::K_BWD, FIELD_TOP);
    // leftmost entry 0 gets an out-of-range letter: its old value has no inverse
    send_load(rsm_pkg::K_LOAD_POS, rsm_pkg::NUM_ROTORS - 1, 0, 0, $urandom);
    send_load(rsm_pkg::K_LOAD_WIRE, rsm_pkg::NUM_ROTORS - 1, 0, FIELD_TOP, $urandom);
    send_letter(rsm_pkg::K_BWD, perm_loaded[rsm_pkg::NUM_ROTORS - 1][0]);
    repeat (2) send_letter(rsm_pkg::K_FWD, rand_letter());
    send_load(rsm_pkg::K_LOAD_WIRE, rsm_pkg::NUM_ROTORS - 1, 0,
              perm_loaded[rsm_pkg::NUM_ROTORS - 1][0], $urandom);
    send_letter(rsm_pkg::K_BWD, perm_loaded[rsm_pkg::NUM_ROTORS - 1][0]);
    finish_burst();
  endtask

  task automatic test_ignored_kinds();
    word_t w;
    for (int k = int'(rsm_pkg::K_BWD) + 1; k <= KIND_TOP; k++) begin
      w = random_word();
      w.kind = rsm_pkg::KIND_W'(k);
      send_word(w);
    end
    send_letter(rsm_pkg::K_FWD, rand_letter());
    finish_burst();
  endtask

  task automatic test_output_stall();
    hold_req = HOLD_CYCLES;
    repeat (8) send_letter(rsm_pkg::K_FWD, rand_letter());
    finish_burst();
  endtask

  task automatic test_random(int target);
    int start, op;
    word_t w;
    start = n_counted;
    while (n_counted - start < target) begin
      if (n_counted - start >= target - CALM_WORDS) calm = 1'b1;
      op = $urandom_range(0, 99);
      w = random_word();
      if (op < 2) begin
        reload_rotor($urandom_range(0, rsm_pkg::NUM_ROTORS - 1));
      end else if (op < 8) begin
        w.kind = rsm_pkg::K_LOAD_WIRE;
        w.idx  = ($urandom_range(0, 7) == 0)
                 ? rsm_pkg::letter_t'($urandom_range(rsm_pkg::LETTERS, FIELD_TOP))
                 : rsm_pkg::letter_t'($urandom_range(0, rsm_pkg::LETTERS - 1));
        w.val  = rand_letter();
        send_word(w);
      end else if (op < 13) begin
        w.kind = rsm_pkg::K_LOAD_NOTCH;
        case ($urandom_range(0, 3))
          0: w.notch = '0;
          1: w.notch = '1;
          2: w.notch = rsm_pkg::notch_t'(1) << $urandom_range(0, rsm_pkg::NOTCH_W - 1);
          default: w.notch = rsm_pkg::notch_t'($urandom);
        endcase
        send_word(w);
      end else if (op < 18) begin
        w.kind = rsm_pkg::K_LOAD_POS;
        send_word(w);
      end else if (op < 20) begin
        w.kind = rsm_pkg::KIND_W'($urandom_range(int'(rsm_pkg::K_BWD) + 1, KIND_TOP));
        send_word(w);
      end else begin
        w.kind   = (op < 60) ? rsm_pkg::K_FWD : rsm_pkg::K_BWD;
        w.letter = rand_letter();
        send_word(w);
      end
    end
    finish_burst();
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= '0;
    in_ch.rotor_sel   <= '0;
    in_ch.entry_index <= '0;
    in_ch.value       <= '0;
    in_ch.notch_bits  <= '0;
    in_ch.letter      <= '0;
    calm = 1'b0;
    hold_req = 0;
    for (int r = 0; r < rsm_pkg::NUM_ROTORS; r++) begin
      notch_mask[r] = '0;
      rotor_pos[r]  = 0;
      need_step[r]  = 1'b0;
      stepped[r]    = 1'b0;
      for (int i = 0; i < rsm_pkg::LETTERS; i++) wire_map[r][i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wiring_setup();
    test_forward_extremes();
    test_stepping_carry();
    test_backward_lookup();
    test_ignored_kinds();
    test_output_stall();
    test_random(950);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d loads, %0d forward and %0d backward letters, %0d ignored words.",
             n_loads, n_fwd, n_bwd, n_ignored);
    $display("%0d result words checked; %0d rotor lookups had no inverse entry.",
             n_checked, n_no_inverse);
    if (n_errors == 0 && expected_letters.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT: results still outstanding: %0d", expected_letters.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: rotor_stack_step_and_map_core.f
sv/rsm_pkg.sv
sv/rsm_if.sv
sv/rsm_mod_unit.sv
sv/rsm_wiring_ram.sv
sv/rotor_stack_step_and_map_core.sv
verif/tb_rotor_stack_step_and_map_core.sv
